// ===== src/s2f_pkg.sv =====
// Shared types, codes and conversion helpers for the sample to float converter.
package s2f_pkg;

	typedef enum logic [2:0] {
		SRC_U8    = 3'd0,
		SRC_U16   = 3'd1,
		SRC_I16   = 3'd2,
		SRC_U32   = 3'd3,
		SRC_I32   = 3'd4,
		SRC_F16   = 3'd5,
		SRC_F32   = 3'd6,
		SRC_UNSUP = 3'd7
	} src_type_t;

	typedef enum logic [1:0] {
		REG_SOURCE_TYPE = 2'd0,
		REG_OUTPUT_BF16 = 2'd1,
		REG_FILL_RAW    = 2'd2
	} reg_index_t;

	localparam logic [31:0] F32_ABS_MASK = 32'h7fff_ffff;
	localparam logic [31:0] F32_INF      = 32'h7f80_0000;
	localparam logic [15:0] BF16_NAN     = 16'h7fff;

	// Decoded element handed from the front stage to the pack stage
	typedef struct packed {
		logic        is_float;  // result already formed in bits
		logic [31:0] bits;      // float result when is_float
		logic        sign;      // integer sign
		logic [31:0] mag;       // integer magnitude
		logic        bf16;
	} dec_t;

	// Index of the leading one (mag nonzero)
	function automatic logic [4:0] lead_one(input logic [31:0] v);
		logic [4:0] p;
		p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) p = 5'(i);
		end
		return p;
	endfunction

	function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
		logic [4:0]  e;
		logic [9:0]  m;
		logic [4:0]  p;
		logic [3:0]  sh;
		logic [10:0] nm;
		logic [31:0] r;
		e = h[14:10];
		m = h[9:0];
		p = lead_one({22'd0, m});
		sh = 4'(5'd10 - p);
		nm = {1'b0, m} << sh;
		if (e == 5'd0) begin
			if (m == 10'd0) r = {h[15], 31'd0};
			else r = {h[15], 8'(8'd113 - {4'd0, sh}), nm[9:0], 13'd0};
		end else if (e == 5'd31) begin
			r = {h[15], 8'hff, m, 13'd0};
		end else begin
			r = {h[15], 8'({3'd0, e} + 8'd112), m, 13'd0};
		end
		return r;
	endfunction

endpackage

// ===== src/s2f_decode.sv =====
// Front stage: source selection, sign split and half-precision widening.
module s2f_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [31:0]      raw,
	input  logic [2:0]       source_type,
	input  logic             output_bf16,
	output s2f_pkg::dec_t    dec_s1
);
	s2f_pkg::dec_t d;

	always_comb begin
		d = '0;
		d.bf16 = output_bf16;
		case (s2f_pkg::src_type_t'(source_type))
			s2f_pkg::SRC_U8:  d.mag = {24'd0, raw[7:0]};
			s2f_pkg::SRC_U16: d.mag = {16'd0, raw[15:0]};
			s2f_pkg::SRC_I16: begin
				d.sign = raw[15];
				d.mag = raw[15] ? 32'(17'h10000 - {1'b0, raw[15:0]}) : {16'd0, raw[15:0]};
			end
			s2f_pkg::SRC_U32: d.mag = raw;
			s2f_pkg::SRC_I32: begin
				d.sign = raw[31];
				d.mag = raw[31] ? 32'd0 - raw : raw;
			end
			s2f_pkg::SRC_F16: begin
				d.is_float = 1'b1;
				d.bits = s2f_pkg::f16_to_f32(raw[15:0]);
			end
			s2f_pkg::SRC_F32: begin
				d.is_float = 1'b1;
				d.bits = raw;
			end
			default: d.is_float = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dec_s1 <= '0;
		else if (adv) dec_s1 <= d;
	end
endmodule

// ===== src/s2f_pack.sv =====
// Back stage: integer normalise and round (float inputs pass through), then optional bfloat16 narrowing.
module s2f_pack (
	input  s2f_pkg::dec_t dec,
	output logic [31:0]   result
);
	logic [4:0]  pos;
	logic [31:0] norm;
	logic [24:0] mant;
	logic        rbit, sticky;
	logic [7:0]  expo;
	logic [31:0] f;
	logic [31:0] fr;

	always_comb begin
		pos = s2f_pkg::lead_one(dec.mag);
		norm = dec.mag << (5'd31 - pos);  // leading one at bit 31
		rbit = norm[7];
		sticky = |norm[6:0];
		mant = {1'b0, norm[31:8]};
		if (pos > 5'd23 && rbit && (sticky || norm[8])) mant = mant + 25'd1;
		expo = 8'(8'd127 + {3'd0, pos});
		if (mant[24]) begin
			expo = expo + 8'd1;
			mant = mant >> 1;
		end
		if (dec.is_float) f = dec.bits;
		else if (dec.mag == 32'd0) f = {dec.sign, 31'd0};
		else f = {dec.sign, expo, mant[22:0]};
		fr = f + 32'h7fff + {31'd0, f[16]};
		if (!dec.bf16) result = f;
		else if ((f & s2f_pkg::F32_ABS_MASK) > s2f_pkg::F32_INF)
			result = {16'd0, s2f_pkg::BF16_NAN};
		else result = {16'd0, fr[31:16]};
	end
endmodule

// ===== src/sample_to_float_converter.sv =====
// Top level of the sample to float converter.
// Converts one raw element per request to float32 or bfloat16 bits.
// Channels: in_valid/in_ready carry raw_element and element_missing;
// out_valid/out_ready carry converted_bits; cfg_valid/cfg_ready carry
// cfg_index and cfg_data (0 source type, 1 bfloat16 select, 2 fill value).
// A missing element is replaced by the fill value before conversion.
// Two registers lie between input request and result: one decode stage
// (type select, sign split, half widening) and one result register after
// normalise, round and narrow. Throughput is one element per cycle unless the receiver stalls.
// When the receiver stalls, the result register holds and the decode stage
// holds behind it; in_ready drops only when both stages are full.
// Reset clears the stage valid flags, the decode stage and the
// configuration (u8 source, float32 output, zero fill).
// Configuration is taken at any time but should be written while idle.
module sample_to_float_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] raw_element,
	input  logic        element_missing,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] converted_bits,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	logic [2:0]    source_type_q;
	logic          output_bf16_q;
	logic [31:0]   fill_raw_q;
	logic          v_s1, v_s2;
	logic          adv1, adv2;
	s2f_pkg::dec_t dec_s1;
	logic [31:0]   res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_type_q <= '0;
			output_bf16_q <= 1'b0;
			fill_raw_q <= '0;
		end else if (cfg_valid) begin
			case (s2f_pkg::reg_index_t'(cfg_index))
				s2f_pkg::REG_SOURCE_TYPE: source_type_q <= cfg_data[2:0];
				s2f_pkg::REG_OUTPUT_BF16: output_bf16_q <= cfg_data[0];
				s2f_pkg::REG_FILL_RAW:    fill_raw_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv2 = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || adv2;
	assign adv1 = in_valid && in_ready;

	s2f_decode u_dec (
		.clk(clk), .arst_n(arst_n), .adv(adv1),
		.raw(element_missing ? fill_raw_q : raw_element),
		.source_type(source_type_q), .output_bf16(output_bf16_q),
		.dec_s1(dec_s1)
	);

	s2f_pack u_pack (.dec(dec_s1), .result(res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= 1'b1;
			else if (adv2) v_s1 <= 1'b0;
			if (adv2) v_s2 <= 1'b1;
			else if (out_ready) v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) converted_bits <= res;
	end

	assign out_valid = v_s2;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(converted_bits))
		else $error("result changed under stall");
	a_bf16_upper: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 && dec_s1.bf16 |=> converted_bits[31:16] == 16'd0)
		else $error("bfloat16 result has upper bits");
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && !out_ready |-> !in_ready)
		else $error("accepted into full pipe");
endmodule

// ===== dv/tb_sample_to_float_converter.sv =====
// Testbench for the sample to float converter: directed and random elements, self-checking.
module tb_sample_to_float_converter;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] raw_element;
	logic        element_missing;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] converted_bits;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	s2f_pkg::src_type_t cur_type;
	logic               cur_bf16;
	logic [31:0]        cur_fill;

	logic [31:0] expected_bits_q[$];
	int          mismatch_count;
	int          send_idle_pct;
	int          recv_idle_pct;

	sample_to_float_converter u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_element(raw_element), .element_missing(element_missing),
		.out_valid(out_valid), .out_ready(out_ready), .converted_bits(converted_bits),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Magnitude to float32 with round to nearest even
	function automatic logic [31:0] mag_to_single(input logic neg, input logic [31:0] mag);
		int          msb;
		logic [7:0]  ex;
		logic [32:0] mant;
		logic [31:0] rem;
		logic [31:0] half;
		int          sh;
		msb = 0;
		if (mag == 0) return {neg, 31'd0};
		for (int i = 0; i < 32; i++) if (mag[i]) msb = i;
		ex = 8'(127 + msb);
		if (msb <= 23) begin
			mant = 33'(mag) << (23 - msb);
		end else begin
			sh = msb - 23;
			rem = mag & ((32'd1 << sh) - 1);
			half = 32'd1 << (sh - 1);
			mant = 33'(mag >> sh);
			if (rem > half || (rem == half && mant[0])) mant = mant + 1;
			if (mant == 33'h100_0000) begin
				mant = mant >> 1;
				ex = ex + 1;
			end
		end
		return {neg, ex, mant[22:0]};
	endfunction

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [4:0] e;
		logic [10:0] m;
		int          sh;
		e = h[14:10];
		m = {1'b0, h[9:0]};
		sh = 0;
		if (e == 0) begin
			if (m == 0) return {h[15], 31'd0};
			while (!m[10]) begin
				m = m << 1;
				sh++;
			end
			return {h[15], 8'(113 - sh), m[9:0], 13'd0};
		end
		return {h[15], (e == 5'd31) ? 8'hff : 8'(e + 112), h[9:0], 13'd0};
	endfunction

	function automatic logic [31:0] predict_converted(input logic [31:0] raw, input logic miss);
		logic [31:0] v;
		logic [31:0] f;
		v = miss ? cur_fill : raw;
		case (cur_type)
			s2f_pkg::SRC_U8:  f = mag_to_single(1'b0, {24'd0, v[7:0]});
			s2f_pkg::SRC_U16: f = mag_to_single(1'b0, {16'd0, v[15:0]});
			s2f_pkg::SRC_I16: f = v[15] ? mag_to_single(1'b1, 32'h1_0000 - {16'd0, v[15:0]})
			                            : mag_to_single(1'b0, {16'd0, v[15:0]});
			s2f_pkg::SRC_U32: f = mag_to_single(1'b0, v);
			s2f_pkg::SRC_I32: f = v[31] ? mag_to_single(1'b1, -v) : mag_to_single(1'b0, v);
			s2f_pkg::SRC_F16: f = half_to_single(v[15:0]);
			s2f_pkg::SRC_F32: f = v;
			default: f = 32'd0;
		endcase
		if (!cur_bf16) return f;
		if ((f & s2f_pkg::F32_ABS_MASK) > s2f_pkg::F32_INF) return {16'd0, s2f_pkg::BF16_NAN};
		return {16'd0, 16'((f + 32'h7fff + {31'd0, f[16]}) >> 16)};
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%s at %0t", msg, $time);
		mismatch_count++;
	endtask

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_bits_q.size() == 0) begin
				report_mismatch($sformatf("Unexpected result %h", converted_bits));
			end else begin
				logic [31:0] want;
				want = expected_bits_q.pop_front();
				if (converted_bits !== want)
					report_mismatch($sformatf("converted_bits mismatch: got %h want %h",
						converted_bits, want));
			end
		end
	end

	// Receiver stall
	always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// Leaves in_valid high after the handshake; a drain, or an idle gap in the next send, drops it
	task automatic send_element(input logic [31:0] raw, input logic miss);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		raw_element <= raw;
		element_missing <= miss;
		expected_bits_q.push_back(predict_converted(raw, miss));
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_bits_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input s2f_pkg::reg_index_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			s2f_pkg::REG_SOURCE_TYPE: cur_type = s2f_pkg::src_type_t'(data[2:0]);
			s2f_pkg::REG_OUTPUT_BF16: cur_bf16 = data[0];
			default:                  cur_fill = data;
		endcase
		@(negedge clk);
	endtask

	task automatic set_mode(input s2f_pkg::src_type_t st, input logic bf,
		input logic [31:0] fill);
		drain();
		write_reg(s2f_pkg::REG_SOURCE_TYPE, {29'd0, st});
		write_reg(s2f_pkg::REG_OUTPUT_BF16, {31'd0, bf});
		write_reg(s2f_pkg::REG_FILL_RAW, fill);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_raw();
		case ($urandom_range(5))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return {16'd0, 16'($urandom_range(16'hffff))};
			3: return 32'h1 << $urandom_range(31);
			default: return $urandom();
		endcase
	endfunction

	task automatic test_directed;
		set_mode(s2f_pkg::SRC_U8, 1'b0, 32'd0);
		send_element(32'h0000_00ff, 1'b0);
		send_element(32'hffff_ff00, 1'b0);
		set_mode(s2f_pkg::SRC_I16, 1'b0, 32'h0000_8000);
		send_element(32'h0000_7fff, 1'b0);
		send_element(32'h0000_8000, 1'b0);
		send_element(32'h0, 1'b1);
		set_mode(s2f_pkg::SRC_U32, 1'b0, 32'hffff_ffff);
		send_element(32'h0100_0001, 1'b0);
		send_element(32'h0100_0003, 1'b0);
		send_element(32'h0, 1'b1);
		set_mode(s2f_pkg::SRC_I32, 1'b1, 32'h8000_0000);
		send_element(32'h8000_0000, 1'b0);
		send_element(32'h7fff_ffff, 1'b0);
		send_element(32'h0, 1'b1);
		set_mode(s2f_pkg::SRC_F16, 1'b0, 32'h0000_7c01);
		send_element(32'h0000_0001, 1'b0);
		send_element(32'h0000_83ff, 1'b0);
		send_element(32'h0000_fc00, 1'b0);
		send_element(32'h0, 1'b1);
		set_mode(s2f_pkg::SRC_F32, 1'b1, 32'h7fc0_0001);
		send_element(32'h3f80_8000, 1'b0);
		send_element(32'h3f81_8000, 1'b0);
		send_element(32'hff80_0000, 1'b0);
		send_element(32'h0, 1'b1);
		set_mode(s2f_pkg::SRC_UNSUP, 1'b1, 32'hffff_ffff);
		send_element(32'hffff_ffff, 1'b0);
		send_element(32'h0, 1'b1);
	endtask

	task automatic test_random(input int n_items);
		for (int i = 0; i < n_items; i++) begin
			if (i % 50 == 0)
				set_mode(s2f_pkg::src_type_t'(3'($urandom_range(7))),
					1'($urandom_range(1)), rand_raw());
			send_element(rand_raw(), ($urandom_range(9) == 0));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_element = '0;
		element_missing = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = s2f_pkg::REG_SOURCE_TYPE;
		cfg_data = '0;
		cur_type = s2f_pkg::SRC_U8;
		cur_bf16 = 1'b0;
		cur_fill = '0;
		mismatch_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		send_idle_pct = 22;
		recv_idle_pct = 67;
		test_random(400);
		// hold off until every outstanding request has completed
		drain();
		send_idle_pct = 67;
		recv_idle_pct = 22;
		test_random(400);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(400);
		drain();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
src/s2f_pkg.sv
src/s2f_decode.sv
src/s2f_pack.sv
src/sample_to_float_converter.sv
dv/tb_sample_to_float_converter.sv
